>>> hw/rtl/actor_mailbox_queue_engine_core_assert.svh
// -----------------------------------------------------------------------------
// actor mailbox queue engine assertion macros
// concurrent checks used at the end of the core
// -----------------------------------------------------------------------------
`ifndef ACTOR_MAILBOX_QUEUE_ENGINE_CORE_ASSERT_SVH
`define ACTOR_MAILBOX_QUEUE_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define AMQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/amq_pkg.sv
// -----------------------------------------------------------------------------
// amq_pkg
// shared widths, command and status codes, and item types of the mailbox engine
// -----------------------------------------------------------------------------
package amq_pkg;

   localparam int CMD_W      = 3;
   localparam int HANDLE_W   = 6;
   localparam int TAG_W      = 4;
   localparam int WORD_W     = 32;
   localparam int STATUS_W   = 4;
   localparam int DEPTH_W    = 4;
   localparam int ENTRY_W    = 2 * WORD_W;

   localparam int REQ_ITEM_W  = CMD_W + HANDLE_W + TAG_W + 2 * WORD_W;
   localparam int RSP_ITEM_W  = STATUS_W + WORD_W + DEPTH_W + WORD_W + TAG_W;
   localparam int REQ_TDATA_W = ((REQ_ITEM_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_ITEM_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_ITEM_W;

   localparam logic [CMD_W-1:0] CMD_BIND     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ENQUEUE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DRAIN    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_REPORT   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_SHUTDOWN = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_HANDLE = 4'd1;
   localparam logic [STATUS_W-1:0] ST_STALE      = 4'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_EXEC   = 4'd3;
   localparam logic [STATUS_W-1:0] ST_UNBOUND    = 4'd4;
   localparam logic [STATUS_W-1:0] ST_MISMATCH   = 4'd5;
   localparam logic [STATUS_W-1:0] ST_SHUTDOWN   = 4'd6;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 4'd7;
   localparam logic [STATUS_W-1:0] ST_DRIFT      = 4'd8;
   localparam logic [STATUS_W-1:0] ST_METHOD_ERR = 4'd9;
   localparam logic [STATUS_W-1:0] ST_FULL       = 4'd10;

   // first field in the highest bits
   typedef struct packed {
      logic signed [WORD_W-1:0] fault_word;
      logic signed [WORD_W-1:0] enqueue_value;
      logic [TAG_W-1:0]         exec_id;
      logic [HANDLE_W-1:0]      actor_ref;
      logic [CMD_W-1:0]         command;
   } req_item_type;

   typedef struct packed {
      logic [TAG_W-1:0]         expected_executor;
      logic [WORD_W-1:0]        message_number;
      logic [DEPTH_W-1:0]       queue_depth;
      logic signed [WORD_W-1:0] result_value;
      logic [STATUS_W-1:0]      status;
   } rsp_item_type;

   typedef struct packed {
      logic bind_we;
      logic shut_set;
      logic queue_we;
      logic last_we;
      logic seq_we;
      logic mem_we;
   } upd_type;

endpackage

>>> hw/rtl/actor_mailbox_queue_engine_core.sv
// -----------------------------------------------------------------------------
// actor_mailbox_queue_engine_core
// per-actor bounded mailboxes with executor binding and shutdown flags
//
// usage:
//   req channel carries one command item (bind, enqueue, drain, cancel,
//   report error, shutdown); rsp channel returns one result item per known
//   command, unknown command codes are consumed and give no result.
//   on accept the actor's table entries are snapshotted and the message
//   memory is read (head slot for drain, newest slot for cancel/shutdown).
//   the work stage then checks and acts on the item and loads the result register.
//   throughput: one item per cycle while the result register is not held; the next item's snapshot and memory read
//   take the updates of the item in flight by forwarding and bypass.
//   reset: bindings, shutdown flags, heads, counts, last completed numbers
//   and the message counter clear at once; message memory is not cleared,
//   only slots holding queued messages are ever used.
//   receiver stall: the result register holds and req_tready drops until
//   rsp_tready returns, so the whole pipeline freezes.
// -----------------------------------------------------------------------------
`include "actor_mailbox_queue_engine_core_assert.svh"

module actor_mailbox_queue_engine_core import amq_pkg::*; #(
   parameter int NUM_ACTORS    = 16,
   parameter int NUM_EXECUTORS = 4,
   parameter int QUEUE_DEPTH   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // command, actor_ref, exec_id, enqueue_value, fault_word
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status, result_value, queue_depth, message_number, expected_executor
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int ACTOR_W = (NUM_ACTORS > 1) ? $clog2(NUM_ACTORS) : 1;
   localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [COUNT_W:0] QD_WIDE = (COUNT_W + 1)'(QUEUE_DEPTH);

   // actor tables
   logic [TAG_W-1:0]   bind_ff  [NUM_ACTORS];
   logic               shut_ff  [NUM_ACTORS];
   logic [SLOT_W-1:0]  head_ff  [NUM_ACTORS];
   logic [COUNT_W-1:0] count_ff [NUM_ACTORS];
   logic [WORD_W-1:0]  last_ff  [NUM_ACTORS];
   logic [WORD_W-1:0]  seq_ff;

   // work stage
   logic               stg_valid_ff;
   req_item_type       stg_item_ff;
   logic               stg_handle_ok_ff;
   logic [ACTOR_W-1:0] stg_actor_ff;
   logic [TAG_W-1:0]   stg_bound_ff;
   logic               stg_shut_ff;
   logic [SLOT_W-1:0]  stg_head_ff;
   logic [COUNT_W-1:0] stg_count_ff;
   logic [WORD_W-1:0]  stg_last_ff;
   logic               byp_hit_ff;
   logic [ENTRY_W-1:0] byp_data_ff;

   // result register
   logic               rsp_valid_ff;
   rsp_item_type       rsp_item_ff;

   logic               advance;
   logic               accept;
   logic               fire;
   req_item_type       in_item;
   logic               in_handle_ok;
   logic [ACTOR_W-1:0] in_actor;
   logic               fwd;
   logic [TAG_W-1:0]   snap_bound_in;
   logic               snap_shut_in;
   logic [SLOT_W-1:0]  snap_head_in;
   logic [COUNT_W-1:0] snap_count_in;
   logic [WORD_W-1:0]  snap_last_in;
   logic [COUNT_W:0]   tail_sum;
   logic [SLOT_W-1:0]  tail_slot;
   logic [SLOT_W-1:0]  rd_slot;
   logic               byp_hit_in;
   logic [ENTRY_W-1:0] mem_rd_data;
   logic [ENTRY_W-1:0] entry;

   logic               ex_rsp_valid;
   rsp_item_type       ex_rsp;
   upd_type            ex_upd;
   logic [TAG_W-1:0]   ex_new_bound;
   logic               ex_new_shut;
   logic [SLOT_W-1:0]  ex_new_head;
   logic [COUNT_W-1:0] ex_new_count;
   logic [WORD_W-1:0]  ex_new_last;
   logic [WORD_W-1:0]  ex_new_seq;
   logic [SLOT_W-1:0]  ex_wr_slot;
   logic [ENTRY_W-1:0] ex_wr_data;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && advance;
   assign fire       = stg_valid_ff && advance;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0), rsp_item_ff};

   // incoming item decode and snapshot with forwarding from the item in flight
   assign in_item      = req_item_type'(req_tdata[REQ_ITEM_W-1:0]);
   assign in_handle_ok = (in_item.actor_ref != '0) &&
                         (in_item.actor_ref <= HANDLE_W'(NUM_ACTORS));
   assign in_actor     = in_handle_ok ? ACTOR_W'(in_item.actor_ref - HANDLE_W'(1)) : '0;
   assign fwd          = stg_valid_ff && stg_handle_ok_ff && (stg_actor_ff == in_actor);

   assign snap_bound_in = fwd ? ex_new_bound : bind_ff[in_actor];
   assign snap_shut_in  = fwd ? ex_new_shut  : shut_ff[in_actor];
   assign snap_head_in  = fwd ? ex_new_head  : head_ff[in_actor];
   assign snap_count_in = fwd ? ex_new_count : count_ff[in_actor];
   assign snap_last_in  = fwd ? ex_new_last  : last_ff[in_actor];

   // newest message slot for cancel and shutdown
   assign tail_sum  = (COUNT_W + 1)'(snap_head_in) + (COUNT_W + 1)'(snap_count_in)
                      - (COUNT_W + 1)'(1);
   assign tail_slot = (tail_sum >= QD_WIDE) ? SLOT_W'(tail_sum - QD_WIDE)
                                            : SLOT_W'(tail_sum);
   assign rd_slot   = (in_item.command == CMD_DRAIN) ? snap_head_in : tail_slot;

   assign byp_hit_in = fwd && ex_upd.mem_we && (ex_wr_slot == rd_slot);
   assign entry      = byp_hit_ff ? byp_data_ff : mem_rd_data;

   amq_store #(
      .NUM_ACTORS  (NUM_ACTORS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock    (clock),
      .wr_en    (fire && ex_upd.mem_we),
      .wr_actor (stg_actor_ff),
      .wr_slot  (ex_wr_slot),
      .wr_data  (ex_wr_data),
      .rd_en    (accept),
      .rd_actor (in_actor),
      .rd_slot  (rd_slot),
      .rd_data  (mem_rd_data)
   );

   amq_exec #(
      .NUM_EXECUTORS (NUM_EXECUTORS),
      .QUEUE_DEPTH   (QUEUE_DEPTH)
   ) u_exec (
      .item      (stg_item_ff),
      .handle_ok (stg_handle_ok_ff),
      .bound     (stg_bound_ff),
      .shut      (stg_shut_ff),
      .head      (stg_head_ff),
      .count     (stg_count_ff),
      .last      (stg_last_ff),
      .seq       (seq_ff),
      .entry     (entry),
      .rsp_valid (ex_rsp_valid),
      .rsp       (ex_rsp),
      .upd       (ex_upd),
      .new_bound (ex_new_bound),
      .new_shut  (ex_new_shut),
      .new_head  (ex_new_head),
      .new_count (ex_new_count),
      .new_last  (ex_new_last),
      .new_seq   (ex_new_seq),
      .wr_slot   (ex_wr_slot),
      .wr_data   (ex_wr_data)
   );

   // tables and message counter
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_ACTORS; i++) begin
            bind_ff[i]  <= '0;
            shut_ff[i]  <= 1'b0;
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
            last_ff[i]  <= '0;
         end
         seq_ff <= '0;
      end else if (fire && stg_handle_ok_ff && ex_rsp_valid) begin
         if (ex_upd.bind_we) begin
            bind_ff[stg_actor_ff] <= ex_new_bound;
         end
         if (ex_upd.shut_set) begin
            shut_ff[stg_actor_ff] <= 1'b1;
         end
         if (ex_upd.queue_we) begin
            head_ff[stg_actor_ff]  <= ex_new_head;
            count_ff[stg_actor_ff] <= ex_new_count;
         end
         if (ex_upd.last_we) begin
            last_ff[stg_actor_ff] <= ex_new_last;
         end
         if (ex_upd.seq_we) begin
            seq_ff <= ex_new_seq;
         end
      end
   end

   // work stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (advance) begin
         stg_valid_ff <= req_tvalid;
      end
   end

   // work stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         stg_item_ff      <= in_item;
         stg_handle_ok_ff <= in_handle_ok;
         stg_actor_ff     <= in_actor;
         stg_bound_ff     <= snap_bound_in;
         stg_shut_ff      <= snap_shut_in;
         stg_head_ff      <= snap_head_in;
         stg_count_ff     <= snap_count_in;
         stg_last_ff      <= snap_last_in;
         byp_hit_ff       <= byp_hit_in;
         byp_data_ff      <= ex_wr_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stg_valid_ff && ex_rsp_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_item_ff <= ex_rsp;
      end
   end

   `AMQ_ASSERT_NOW(a_stall_only_on_held_result, clock, reset,
      !req_tready, rsp_tvalid, "input stalled without a pending result")

   `AMQ_ASSERT_NOW(a_seq_steps_by_one, clock, reset,
      !$past(reset) && (seq_ff != $past(seq_ff)), seq_ff == $past(seq_ff) + WORD_W'(1),
      "message counter moved by other than one")

   `AMQ_ASSERT_NOW(a_count_in_bound, clock, reset,
      stg_valid_ff, stg_count_ff <= COUNT_W'(QUEUE_DEPTH),
      "mailbox count beyond queue depth")

   `AMQ_ASSERT_NEXT(a_result_follows_fire, clock, reset,
      fire && ex_rsp_valid, rsp_tvalid, "processed item gave no result")

endmodule

>>> hw/rtl/amq_store.sv
// -----------------------------------------------------------------------------
// amq_store
// mailbox message memory, one write port and one registered read port
// -----------------------------------------------------------------------------
module amq_store import amq_pkg::*; #(
   parameter int NUM_ACTORS  = 16,
   parameter int QUEUE_DEPTH = 8,
   localparam int ACTOR_W = (NUM_ACTORS > 1) ? $clog2(NUM_ACTORS) : 1,
   localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ACTOR_W-1:0] wr_actor,
   input  logic [SLOT_W-1:0]  wr_slot,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ACTOR_W-1:0] rd_actor,
   input  logic [SLOT_W-1:0]  rd_slot,
   output logic [ENTRY_W-1:0] rd_data
);

   // message number in the upper word, value in the lower word
   logic [ENTRY_W-1:0] mem [NUM_ACTORS][QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_actor][wr_slot] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_actor][rd_slot];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/amq_exec.sv
// -----------------------------------------------------------------------------
// amq_exec
// command checks and actions for one item against its actor's table snapshot
// -----------------------------------------------------------------------------
module amq_exec import amq_pkg::*; #(
   parameter int NUM_EXECUTORS = 4,
   parameter int QUEUE_DEPTH   = 8,
   localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  req_item_type       item,
   input  logic               handle_ok,
   input  logic [TAG_W-1:0]   bound,
   input  logic               shut,
   input  logic [SLOT_W-1:0]  head,
   input  logic [COUNT_W-1:0] count,
   input  logic [WORD_W-1:0]  last,
   input  logic [WORD_W-1:0]  seq,
   input  logic [ENTRY_W-1:0] entry,
   output logic               rsp_valid,
   output rsp_item_type       rsp,
   output upd_type            upd,
   output logic [TAG_W-1:0]   new_bound,
   output logic               new_shut,
   output logic [SLOT_W-1:0]  new_head,
   output logic [COUNT_W-1:0] new_count,
   output logic [WORD_W-1:0]  new_last,
   output logic [WORD_W-1:0]  new_seq,
   output logic [SLOT_W-1:0]  wr_slot,
   output logic [ENTRY_W-1:0] wr_data
);

   localparam logic [COUNT_W:0] QD_WIDE = (COUNT_W + 1)'(QUEUE_DEPTH);

   logic               tag_ok;
   logic               full;
   logic [COUNT_W:0]   tail_sum;
   logic [SLOT_W-1:0]  head_next;
   logic [WORD_W-1:0]  entry_num;
   logic [WORD_W-1:0]  entry_val;

   assign tag_ok    = (item.exec_id != '0) &&
                      (item.exec_id <= TAG_W'(NUM_EXECUTORS));
   assign full      = (count == COUNT_W'(QUEUE_DEPTH));
   assign tail_sum  = (COUNT_W + 1)'(head) + (COUNT_W + 1)'(count);
   assign wr_slot   = (tail_sum >= QD_WIDE) ? SLOT_W'(tail_sum - QD_WIDE)
                                            : SLOT_W'(tail_sum);
   assign head_next = (head == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head + SLOT_W'(1);
   assign entry_num = entry[ENTRY_W-1:WORD_W];
   assign entry_val = entry[WORD_W-1:0];
   assign new_seq   = seq + WORD_W'(1);
   assign wr_data   = {new_seq, item.enqueue_value};
   assign rsp_valid = (item.command <= CMD_SHUTDOWN);
   assign new_shut  = shut | upd.shut_set;

   always_comb begin
      rsp       = '0;
      upd       = '0;
      new_bound = bound;
      new_head  = head;
      new_count = count;
      new_last  = last;
      priority if (!handle_ok) begin
         rsp.status = ST_BAD_HANDLE;
      end else if (item.command == CMD_BIND) begin
         priority if (shut) begin
            rsp.status = ST_STALE;
         end else if (!tag_ok) begin
            rsp.status = ST_BAD_EXEC;
         end else begin
            rsp.status            = ST_OK;
            rsp.result_value      = WORD_W'(item.exec_id);
            rsp.queue_depth       = DEPTH_W'(count);
            rsp.expected_executor = item.exec_id;
            upd.bind_we           = 1'b1;
            new_bound             = item.exec_id;
         end
      end else begin
         rsp.queue_depth = DEPTH_W'(count);
         priority if (!tag_ok) begin
            rsp.status = ST_BAD_EXEC;
         end else if (bound == '0) begin
            rsp.status = ST_UNBOUND;
         end else begin
            rsp.expected_executor = bound;
            priority if (bound != item.exec_id) begin
               rsp.status = ST_MISMATCH;
            end else if (shut) begin
               rsp.status = ST_SHUTDOWN;
            end else begin
               unique case (item.command)
                  CMD_ENQUEUE: begin
                     if (full) begin
                        rsp.status = ST_FULL;
                     end else begin
                        rsp.status         = ST_OK;
                        rsp.result_value   = item.enqueue_value;
                        rsp.queue_depth    = DEPTH_W'(count + COUNT_W'(1));
                        rsp.message_number = new_seq;
                        upd.seq_we         = 1'b1;
                        upd.mem_we         = 1'b1;
                        upd.queue_we       = 1'b1;
                        new_count          = count + COUNT_W'(1);
                     end
                  end
                  CMD_DRAIN: begin
                     priority if (count == '0) begin
                        rsp.status = ST_EMPTY;
                     end else if (entry_num <= last) begin
                        rsp.status = ST_DRIFT;
                     end else begin
                        rsp.status         = ST_OK;
                        rsp.result_value   = entry_val;
                        rsp.queue_depth    = DEPTH_W'(count - COUNT_W'(1));
                        rsp.message_number = entry_num;
                        upd.last_we        = 1'b1;
                        upd.queue_we       = 1'b1;
                        new_last           = entry_num;
                        new_head           = head_next;
                        new_count          = count - COUNT_W'(1);
                     end
                  end
                  CMD_REPORT: begin
                     rsp.status       = ST_METHOD_ERR;
                     rsp.result_value = item.fault_word;
                  end
                  CMD_CANCEL, CMD_SHUTDOWN: begin
                     // entry holds the newest message when the mailbox is not empty
                     rsp.status       = ST_OK;
                     rsp.result_value = WORD_W'(count);
                     rsp.queue_depth  = '0;
                     upd.queue_we     = 1'b1;
                     upd.shut_set     = (item.command == CMD_SHUTDOWN);
                     new_head         = '0;
                     new_count        = '0;
                     if (count != '0) begin
                        upd.last_we = 1'b1;
                        new_last    = entry_num;
                     end
                  end
                  default: begin
                     rsp.status = ST_OK;
                  end
               endcase
            end
         end
      end
   end

endmodule
